// ===== sv/mcce_pkg.sv =====
`default_nettype none

package mcce_pkg;

  // Pixels per character cell (2 columns by 3 rows).
  localparam int unsigned NUM_PIX = 6;
  // Width of a per-pixel occurrence count (1 to 6).
  localparam int unsigned CNT_W = 3;
  // Width of a stored colour attribute.
  localparam int unsigned COL_W = 3;
  // Words one cell can produce.
  localparam int unsigned MAX_WORDS = 3;

  // Colour code and mosaic character bases.
  localparam logic [7:0] CODE_FORE    = 8'h80;
  localparam logic [7:0] CODE_BACK    = 8'h90;
  localparam logic [7:0] MOSAIC_BLANK = 8'h20;
  localparam logic [7:0] MOSAIC_LOW   = 8'hA0;
  localparam logic [7:0] MOSAIC_FULL  = 8'hDF;
  localparam logic [7:0] MOSAIC_HIGH  = 8'hE0;

  // One input word: a character cell.
  typedef struct packed {
    logic       row_start;
    logic [7:0] pix_top_left;
    logic [7:0] pix_top_right;
    logic [7:0] pix_mid_left;
    logic [7:0] pix_mid_right;
    logic [7:0] pix_bot_left;
    logic [7:0] pix_bot_right;
  } in_t;

  // One output word: a code byte or the mosaic character.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_cell;
    logic       colour_clash;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/mcce_lane.sv =====
`default_nettype none

// Counts how often this lane's pixel colour occurs in the cell and flags
// whether an earlier pixel already carries the same colour.
module mcce_lane #(
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned LANE       = 0
) (
  input  logic [PIXEL_BITS-1:0]           pix_i [mcce_pkg::NUM_PIX],
  output logic [mcce_pkg::CNT_W-1:0]      count_o,
  output logic                            seen_o
);

  // Compare this lane's pixel against every pixel of the cell.
  always_comb begin
    count_o = '0;
    seen_o  = 1'b0;
    for (int j = 0; j < mcce_pkg::NUM_PIX; j++) begin
      if (pix_i[j] == pix_i[LANE]) begin
        count_o = count_o + mcce_pkg::CNT_W'(1);
        if (j < int'(LANE)) begin
          seen_o = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mcce_merge.sv =====
`default_nettype none

// Merges the lane results: picks the most common colour (ties toward the
// larger value) and counts the distinct colours of the cell.
module mcce_merge #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic [PIXEL_BITS-1:0]      pix_i   [mcce_pkg::NUM_PIX],
  input  logic [mcce_pkg::CNT_W-1:0] count_i [mcce_pkg::NUM_PIX],
  input  logic [mcce_pkg::NUM_PIX-1:0] seen_i,
  output logic [PIXEL_BITS-1:0]      first_o,
  output logic                       multi_o,
  output logic                       clash_o
);

  logic [mcce_pkg::CNT_W+PIXEL_BITS-1:0] best_key;
  logic [mcce_pkg::CNT_W-1:0]            distinct;

  // Running maximum of the (count, colour) keys.
  always_comb begin
    best_key = {count_i[0], pix_i[0]};
    for (int i = 1; i < mcce_pkg::NUM_PIX; i++) begin
      if ({count_i[i], pix_i[i]} > best_key) begin
        best_key = {count_i[i], pix_i[i]};
      end
    end
    first_o = best_key[PIXEL_BITS-1:0];
  end

  // A pixel with no earlier equal opens a new colour.
  always_comb begin
    distinct = '0;
    for (int i = 0; i < mcce_pkg::NUM_PIX; i++) begin
      distinct = distinct + mcce_pkg::CNT_W'(!seen_i[i]);
    end
    multi_o = (distinct >= mcce_pkg::CNT_W'(2));
    clash_o = (distinct >= mcce_pkg::CNT_W'(3));
  end

endmodule

`default_nettype wire

// ===== sv/mcce_encode.sv =====
`default_nettype none

// Holds the row colour state, chooses the second colour, emits colour
// code words and builds the mosaic character of a cell.
module mcce_encode #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       row_start_i,
  input  logic [PIXEL_BITS-1:0]      pix_i   [mcce_pkg::NUM_PIX],
  input  logic [mcce_pkg::CNT_W-1:0] count_i [mcce_pkg::NUM_PIX],
  input  logic [PIXEL_BITS-1:0]      first_i,
  input  logic                       multi_i,
  input  logic                       clash_i,
  output mcce_pkg::out_t             words_o [mcce_pkg::MAX_WORDS],
  output logic [1:0]                 n_words_o
);

  logic [mcce_pkg::COL_W-1:0] fore_q, fore_d, back_q, back_d;
  logic                       fore_known_q, fore_known_d, back_known_q, back_known_d;
  logic                       fk, bk;
  logic [mcce_pkg::CNT_W+PIXEL_BITS-1:0] sec_key;
  logic [PIXEL_BITS-1:0]      second, hi, lo;
  logic                       fore_emit, back_emit;
  logic [mcce_pkg::NUM_PIX-1:0] pattern;
  logic [7:0]                 mosaic;

  // A row start drops the known colours before anything else.
  assign fk = fore_known_q & ~row_start_i;
  assign bk = back_known_q & ~row_start_i;

  // Second colour: best key among the other colours, else fall back on state.
  always_comb begin
    sec_key = '0;
    for (int i = 0; i < mcce_pkg::NUM_PIX; i++) begin
      if (pix_i[i] != first_i && {count_i[i], pix_i[i]} > sec_key) begin
        sec_key = {count_i[i], pix_i[i]};
      end
    end
    if (multi_i) begin
      second = sec_key[PIXEL_BITS-1:0];
    end else if (!bk) begin
      second = '0;
    end else if (first_i != PIXEL_BITS'(back_q)) begin
      second = PIXEL_BITS'(back_q);
    end else begin
      second = fk ? PIXEL_BITS'(fore_q) : '0;
    end
  end

  // Larger colour goes to the foreground.
  assign hi = (first_i < second) ? second : first_i;
  assign lo = (first_i < second) ? first_i : second;

  // Colour state update.
  always_comb begin
    fore_emit    = (32'(hi) < 32'd8) && !(fk && hi == PIXEL_BITS'(fore_q));
    back_emit    = (32'(lo) < 32'd8) && !(bk && lo == PIXEL_BITS'(back_q));
    fore_d       = fore_emit ? hi[mcce_pkg::COL_W-1:0] : fore_q;
    back_d       = back_emit ? lo[mcce_pkg::COL_W-1:0] : back_q;
    fore_known_d = fk | fore_emit;
    back_known_d = bk | back_emit;
  end

  // Mosaic pattern against the updated background.
  always_comb begin
    for (int i = 0; i < mcce_pkg::NUM_PIX; i++) begin
      pattern[i] = !back_known_d || (pix_i[i] != PIXEL_BITS'(back_d));
    end
    if (pattern == '0) begin
      mosaic = mcce_pkg::MOSAIC_BLANK;
    end else if (!pattern[5]) begin
      mosaic = mcce_pkg::MOSAIC_LOW | {3'b000, pattern[4:0]};
    end else if (pattern == '1) begin
      mosaic = mcce_pkg::MOSAIC_FULL;
    end else begin
      mosaic = mcce_pkg::MOSAIC_HIGH | {3'b000, pattern[4:0]};
    end
  end

  // Pack the words of the cell in emission order.
  always_comb begin
    for (int i = 0; i < mcce_pkg::MAX_WORDS; i++) begin
      words_o[i] = '0;
    end
    n_words_o = 2'd0;
    if (fore_emit) begin
      words_o[n_words_o] = '{out_byte: mcce_pkg::CODE_FORE | {5'b0, hi[2:0]},
                             last_of_cell: 1'b0, colour_clash: clash_i};
      n_words_o = n_words_o + 2'd1;
    end
    if (back_emit) begin
      words_o[n_words_o] = '{out_byte: mcce_pkg::CODE_BACK | {5'b0, lo[2:0]},
                             last_of_cell: 1'b0, colour_clash: clash_i};
      n_words_o = n_words_o + 2'd1;
    end
    words_o[n_words_o] = '{out_byte: mosaic, last_of_cell: 1'b1, colour_clash: clash_i};
    n_words_o = n_words_o + 2'd1;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q       <= '0;
      back_q       <= '0;
      fore_known_q <= 1'b0;
      back_known_q <= 1'b0;
    end else if (load_i) begin
      fore_q       <= fore_d;
      back_q       <= back_d;
      fore_known_q <= fore_known_d;
      back_known_q <= back_known_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mosaic_cell_color_encoder_top.sv =====
`default_nettype none

// Sextant mosaic cell encoder.
// The input channel (in_valid_i/in_ready_o/in_data_i) takes one word per
// character cell: six pixel colours and a row-start flag. The output channel
// (out_valid_o/out_ready_i/out_data_o) gives one to three words per cell: an
// optional foreground code, an optional background code and the mosaic
// character, which carries last_of_cell. colour_clash is the same on every
// word of a cell.
// The first word of a cell is offered once the cell has passed the lane
// stage register and the merge stage register and has been loaded into the
// output queue (encode feeds the queue). The single output queue sends one
// word per cycle while out_ready_i is high, and loads the next cell as the
// last word of a cell is taken.
// Six lanes count the colour occurrences in parallel; a merge stage picks
// the dominant colour; the encode stage updates the row colour state.
// Reset clears the pipeline, the output queue and the colour state (both
// colours unset). When the receiver stalls, words hold in the output queue
// and the pipeline fills up and then deasserts in_ready_o.
module mosaic_cell_color_encoder_top #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mcce_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mcce_pkg::out_t  out_data_o
);

  localparam int unsigned NP = mcce_pkg::NUM_PIX;
  localparam int unsigned CW = mcce_pkg::CNT_W;

  logic [PIXEL_BITS-1:0] in_pix [NP];
  logic [CW-1:0]         lane_count [NP];
  logic [NP-1:0]         lane_seen;

  logic                  s1_v_q, s1_row_q;
  logic [PIXEL_BITS-1:0] s1_pix_q [NP];
  logic [CW-1:0]         s1_count_q [NP];
  logic [NP-1:0]         s1_seen_q;
  logic                  s1_ready;

  logic [PIXEL_BITS-1:0] m_first;
  logic                  m_multi, m_clash;

  logic                  s2_v_q, s2_row_q, s2_multi_q, s2_clash_q;
  logic [PIXEL_BITS-1:0] s2_pix_q [NP];
  logic [CW-1:0]         s2_count_q [NP];
  logic [PIXEL_BITS-1:0] s2_first_q;
  logic                  s2_ready;

  mcce_pkg::out_t        enc_words [mcce_pkg::MAX_WORDS];
  logic [1:0]            enc_n;
  logic                  load;

  mcce_pkg::out_t        ser_q [mcce_pkg::MAX_WORDS];
  logic [1:0]            ser_n_q;
  logic                  take;

  // Cut each pixel to the configured colour depth.
  assign in_pix[0] = in_data_i.pix_top_left[PIXEL_BITS-1:0];
  assign in_pix[1] = in_data_i.pix_top_right[PIXEL_BITS-1:0];
  assign in_pix[2] = in_data_i.pix_mid_left[PIXEL_BITS-1:0];
  assign in_pix[3] = in_data_i.pix_mid_right[PIXEL_BITS-1:0];
  assign in_pix[4] = in_data_i.pix_bot_left[PIXEL_BITS-1:0];
  assign in_pix[5] = in_data_i.pix_bot_right[PIXEL_BITS-1:0];

  // One counting lane per pixel.
  for (genvar g = 0; g < NP; g++) begin : g_lane
    mcce_lane #(
      .PIXEL_BITS (PIXEL_BITS),
      .LANE       (g)
    ) u_lane (
      .pix_i   (in_pix),
      .count_o (lane_count[g]),
      .seen_o  (lane_seen[g])
    );
  end

  // Handshake chain: a stage moves on when the next one has room.
  assign take       = out_valid_o && out_ready_i;
  assign load       = s2_v_q && ((ser_n_q == 2'd0) || (ser_n_q == 2'd1 && take));
  assign s2_ready   = !s2_v_q || load;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Lane stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_row_q   <= in_data_i.row_start;
      s1_pix_q   <= in_pix;
      s1_count_q <= lane_count;
      s1_seen_q  <= lane_seen;
    end
  end

  mcce_merge #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_merge (
    .pix_i   (s1_pix_q),
    .count_i (s1_count_q),
    .seen_i  (s1_seen_q),
    .first_o (m_first),
    .multi_o (m_multi),
    .clash_o (m_clash)
  );

  // Merge stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_row_q   <= s1_row_q;
      s2_pix_q   <= s1_pix_q;
      s2_count_q <= s1_count_q;
      s2_first_q <= m_first;
      s2_multi_q <= m_multi;
      s2_clash_q <= m_clash;
    end
  end

  mcce_encode #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .row_start_i (s2_row_q),
    .pix_i       (s2_pix_q),
    .count_i     (s2_count_q),
    .first_i     (s2_first_q),
    .multi_i     (s2_multi_q),
    .clash_i     (s2_clash_q),
    .words_o     (enc_words),
    .n_words_o   (enc_n)
  );

  // Output queue: loads a whole cell, then shifts out one word per cycle while the receiver takes words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_n_q <= 2'd0;
    end else if (load) begin
      ser_n_q <= enc_n;
    end else if (take) begin
      ser_n_q <= ser_n_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ser_q <= enc_words;
    end else if (take) begin
      ser_q[0] <= ser_q[1];
      ser_q[1] <= ser_q[2];
    end
  end

  assign out_valid_o = (ser_n_q != 2'd0);
  assign out_data_o  = ser_q[0];

`ifndef ASSERT_OFF
  // The last queued word of a cell is always its mosaic character.
  a_last_is_mosaic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_n_q == 2'd1 |-> ser_q[0].last_of_cell)
    else $error("queue tail is not a mosaic character");

  // Words of one cell agree on the clash flag.
  a_clash_agrees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_n_q == 2'd2 || ser_n_q == 2'd3) |-> ser_q[0].colour_clash == ser_q[1].colour_clash)
    else $error("clash flag differs within a cell");

  // A stalled merge stage keeps its cell.
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !s2_ready |=> s2_v_q && $stable(s2_first_q))
    else $error("merge stage overwritten while stalled");
`endif

endmodule

`default_nettype wire
